@@ rtl/tpe_pkg.sv @@
// shared types and constants for the trapezoidal pulse energy block
// word formats, config register codes, controller states and the
// command/status structs between controller and datapath; no dependencies
package tpe_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int ACC_BITS       = SAMPLE_BITS + 10;
   localparam int FILT_BITS      = 25;
   localparam int ENERGY_BITS    = 17;
   localparam int WIN_BITS       = 9;
   localparam int GAP_BITS       = 10;
   localparam int CSR_DATA_BITS  = 10;

   // config limits and reset values
   localparam int WIN_MAX = 256;
   localparam int GAP_MAX = 512;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 9'd16;
   localparam logic [GAP_BITS-1:0] GAP_RESET = 10'd8;

   // defaults for the top level parameters
   localparam int DEF_DELAY_DEPTH = 1024;
   localparam int DEF_MAX_SAMPLES = 65536;

   // config register indexes
   typedef enum logic [0:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_GAP_LENGTH    = 1'b1
   } csr_index_type;

   // input word
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [FILT_BITS-1:0] filtered;
      logic                        filtered_valid;
      logic [ENERGY_BITS-1:0]      energy;
      logic                        energy_valid;
      logic                        status;
   } rsp_word_type;

   // controller states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_L,
      S_RD_LG,
      S_RD_SPAN,
      S_UPDATE,
      S_TRACK,
      S_DIV_LOAD,
      S_DIV,
      S_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture the accepted word and the clamped window setup
      logic rd_l;      // read the tap L samples back
      logic rd_lg;     // read the tap L+G samples back
      logic rd_span;   // read the tap 2L+G samples back
      logic cap_l;     // start the increment with the L tap
      logic cap_lg;    // subtract the L+G tap
      logic update;    // add the span tap, write the sample, advance pointer
      logic track;     // update running max and min
      logic div_load;  // load max-min into the divider
      logic div_step;  // one restoring division step
      logic emit;      // load the output register
      logic clear;     // clearing pass write after reset
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;         // current word closes the waveform
      logic long_enough;  // enough samples for a trapezoid point
      logic out_free;     // output register can take a word
      logic clear_done;   // clearing pass at the final entry
   } sts_type;

endpackage

@@ rtl/trapezoidal_pulse_energy_top.sv @@
// Trapezoidal pulse energy filter, top level.
// Input channel req_*: one signed sample per word with a last flag closing
// the waveform. Result channel rsp_*: one word per input word, holding the
// unscaled trapezoid value (once 2L+G samples of the waveform have arrived)
// and, on the last word, the energy (max-min)/L or a too-short status.
// Config port csr_*: window length (index 0) and gap length (index 1),
// written with a single cycle strobe while no word is in flight.
// A word steps through three tap reads, update, tracking and the result load;
// a last word with a valid energy also runs the 26-step restoring divider.
// No new word is taken until the result of the current one is loaded, since
// the three tap reads share the single read port of the delay memory, and
// the accumulate, max/min tracking and result load follow them in turn.
// Reset: synchronous; afterwards a clearing pass zeroes the delay memory,
// during which req_ready stays low.
// Stalls: the result sits in an output register, so the next word is taken
// while a result waits; the sequencer holds only when a new result is ready
// and the previous one has not been taken yet.
// Depends on tpe_pkg, tpe_ctrl and tpe_datapath.
module trapezoidal_pulse_energy_top #(
   parameter int DELAY_DEPTH = tpe_pkg::DEF_DELAY_DEPTH,
   parameter int MAX_SAMPLES = tpe_pkg::DEF_MAX_SAMPLES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tpe_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tpe_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_wr_en,
   input  tpe_pkg::csr_index_type              csr_index,
   input  logic [tpe_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import tpe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   tpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   tpe_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ rtl/tpe_ctrl.sv @@
// sequencing state machine of the trapezoidal pulse energy block
// steps the datapath through the clearing pass, delay line reads, update, tracking, division and result load
// depends on tpe_pkg
module tpe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpe_pkg::sts_type sts,
   output tpe_pkg::cmd_type cmd
);
   import tpe_pkg::*;

   localparam int DCW = $clog2(ACC_BITS);

   state_type        state_ff, state_in;
   logic [DCW-1:0]   div_cnt_ff, div_cnt_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD_L;
            end
         end
         S_RD_L: begin
            cmd.rd_l = 1'b1;
            state_in = S_RD_LG;
         end
         S_RD_LG: begin
            cmd.rd_lg = 1'b1;
            cmd.cap_l = 1'b1;
            state_in  = S_RD_SPAN;
         end
         S_RD_SPAN: begin
            cmd.rd_span = 1'b1;
            cmd.cap_lg  = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_TRACK;
         end
         S_TRACK: begin
            cmd.track = 1'b1;
            if (sts.last && sts.long_enough) state_in = S_DIV_LOAD;
            else state_in = S_EMIT;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = DCW'(ACC_BITS - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0) state_in = S_EMIT;
            else div_cnt_in = div_cnt_ff - 1'b1;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // output register is never overwritten while a word waits
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("emit while output register busy");

   // a stalled result holds the controller in place
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !sts.out_free) |=> state_ff == S_EMIT)
      else $error("left emit without delivering");

   // an accepted word starts the read sequence
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_RD_L)
      else $error("accepted word did not start reads");

   // divider ends after its last step
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == '0) |=> state_ff == S_EMIT)
      else $error("divider overran");
`endif

endmodule

@@ rtl/tpe_datapath.sv @@
// datapath of the trapezoidal pulse energy block: config registers, sample
// delay memory, recursive trapezoid accumulator, max/min tracking, restoring
// divider and output register; depends on tpe_pkg
module tpe_datapath #(
   parameter int DELAY_DEPTH = tpe_pkg::DEF_DELAY_DEPTH,
   parameter int MAX_SAMPLES = tpe_pkg::DEF_MAX_SAMPLES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpe_pkg::req_word_type               req_data,
   input  logic                                csr_wr_en,
   input  tpe_pkg::csr_index_type              csr_index,
   input  logic [tpe_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   input  tpe_pkg::cmd_type                    cmd,
   output tpe_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tpe_pkg::rsp_word_type               rsp_data
);
   import tpe_pkg::*;

   localparam int AW   = $clog2(DELAY_DEPTH);
   localparam int DW   = $clog2(DELAY_DEPTH + 1);
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int CW   = ((DW > GAP_BITS) ? DW : GAP_BITS) + 2;
   localparam int XW   = ((DW > CNTW) ? DW : CNTW) + 1;
   localparam int RW   = WIN_BITS + 1;

   // config registers
   logic [WIN_BITS-1:0] win_ff;
   logic [GAP_BITS-1:0] gap_ff;

   // per word registers
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          last_ff;
   logic [WIN_BITS-1:0]           l_ff;
   logic [DW-1:0]                 lg_ff;
   logic [DW-1:0]                 span_ff;

   // waveform state
   logic [AW-1:0]               wp_ff;
   logic [CNTW-1:0]             cnt_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  delta_ff;
   logic signed [ACC_BITS-1:0]  max_ff;
   logic signed [ACC_BITS-1:0]  min_ff;
   logic                        seen_ff;

   // divider
   logic [ACC_BITS-1:0] div_q_ff;
   logic [RW-1:0]       div_r_ff;

   // output register
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   // delay memory
   logic signed [SAMPLE_BITS-1:0] sample_mem [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] mem_rdata_ff;

   logic [CW-1:0]  l_c, g_c, two_l, span_c;
   logic [DW-1:0]  rd_dist, cap_dist;
   logic [DW:0]    addr_diff, addr_wrap;
   logic [AW-1:0]  rd_addr, wp_next;
   logic           mem_we, mem_re, tap_zero, long_enough, cnt_sat;
   logic signed [SAMPLE_BITS-1:0] mem_wdata;
   logic signed [ACC_BITS-1:0]    tap_val, x_ext;
   logic [ACC_BITS-1:0]           range_diff;
   logic [RW-1:0]                 div_sh;
   rsp_word_type                  rsp_next;

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_RESET;
         gap_ff <= GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: win_ff <= csr_wr_data[WIN_BITS-1:0];
            CSR_GAP_LENGTH:    gap_ff <= csr_wr_data[GAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp window and gap so both windows fit the delay line
   always_comb begin
      if (win_ff == '0) l_c = CW'(1);
      else if (win_ff > WIN_BITS'(WIN_MAX)) l_c = CW'(WIN_MAX);
      else l_c = CW'(win_ff);
      if (l_c > CW'(DELAY_DEPTH / 2)) l_c = CW'(DELAY_DEPTH / 2);
      if (gap_ff > GAP_BITS'(GAP_MAX)) g_c = CW'(GAP_MAX);
      else g_c = CW'(gap_ff);
      two_l = l_c << 1;
      if (two_l + g_c > CW'(DELAY_DEPTH)) g_c = CW'(DELAY_DEPTH) - two_l;
      span_c = two_l + g_c;
   end

   // tap address: write pointer minus distance, modulo the depth
   always_comb begin
      if (cmd.rd_l) rd_dist = DW'(l_ff);
      else if (cmd.rd_lg) rd_dist = lg_ff;
      else rd_dist = span_ff;
      addr_diff = (DW + 1)'(wp_ff) - (DW + 1)'(rd_dist);
      if (addr_diff[DW]) addr_wrap = addr_diff + (DW + 1)'(DELAY_DEPTH);
      else addr_wrap = addr_diff;
      rd_addr = addr_wrap[AW-1:0];
   end

   assign mem_re    = cmd.rd_l | cmd.rd_lg | cmd.rd_span;
   assign mem_we    = cmd.update | cmd.clear;
   assign mem_wdata = cmd.clear ? '0 : x_ff;
   assign wp_next   = (wp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   // delay memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) sample_mem[wp_ff] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= sample_mem[rd_addr];
   end

   // taps reaching before the waveform start read as zero
   assign cnt_sat = (cnt_ff >= CNTW'(MAX_SAMPLES));
   always_comb begin
      if (cmd.cap_l) cap_dist = DW'(l_ff);
      else if (cmd.cap_lg) cap_dist = lg_ff;
      else cap_dist = span_ff;
      tap_zero = (XW'(cap_dist) > XW'(cnt_ff)) && !cnt_sat;
      tap_val  = tap_zero ? '0 : ACC_BITS'(mem_rdata_ff);
      x_ext    = ACC_BITS'(x_ff);
   end

   assign long_enough = (XW'(cnt_ff) >= XW'(span_ff)) || cnt_sat;
   assign range_diff  = ACC_BITS'(max_ff - min_ff);
   assign div_sh      = {div_r_ff[RW-2:0], div_q_ff[ACC_BITS-1]};

   // per word capture, increment assembly and divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_data.sample;
         last_ff <= req_data.last;
         l_ff    <= WIN_BITS'(l_c);
         lg_ff   <= DW'(l_c + g_c);
         span_ff <= DW'(span_c);
      end
      if (cmd.cap_l) delta_ff <= x_ext - tap_val;
      if (cmd.cap_lg) delta_ff <= delta_ff - tap_val;
      if (cmd.div_load) begin
         div_q_ff <= range_diff;
         div_r_ff <= '0;
      end else if (cmd.div_step) begin
         if (div_sh >= RW'(l_ff)) begin
            div_r_ff <= div_sh - RW'(l_ff);
            div_q_ff <= {div_q_ff[ACC_BITS-2:0], 1'b1};
         end else begin
            div_r_ff <= div_sh;
            div_q_ff <= {div_q_ff[ACC_BITS-2:0], 1'b0};
         end
      end
   end

   // waveform state: pointer, count, accumulator, extremes
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         max_ff  <= '0;
         min_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         if (cmd.clear) wp_ff <= wp_next;
         if (cmd.update) begin
            wp_ff  <= wp_next;
            acc_ff <= acc_ff + delta_ff + tap_val;
            if (!cnt_sat) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.track && long_enough) begin
            if (!seen_ff) begin
               max_ff  <= acc_ff;
               min_ff  <= acc_ff;
               seen_ff <= 1'b1;
            end else begin
               if (acc_ff > max_ff) max_ff <= acc_ff;
               if (acc_ff < min_ff) min_ff <= acc_ff;
            end
         end
         // waveform closes after its last word goes out
         if (cmd.emit && last_ff) begin
            acc_ff  <= '0;
            cnt_ff  <= '0;
            max_ff  <= '0;
            min_ff  <= '0;
            seen_ff <= 1'b0;
         end
      end
   end

   // result word
   always_comb begin
      rsp_next                = '0;
      rsp_next.filtered_valid = long_enough;
      rsp_next.energy_valid   = last_ff;
      if (long_enough) rsp_next.filtered = acc_ff[FILT_BITS-1:0];
      if (last_ff) begin
         if (long_enough && seen_ff) rsp_next.energy = div_q_ff[ENERGY_BITS-1:0];
         else rsp_next.status = 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to controller
   always_comb begin
      sts             = '0;
      sts.last        = last_ff;
      sts.long_enough = long_enough;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
      sts.clear_done  = (wp_ff == AW'(DELAY_DEPTH - 1));
   end

`ifndef SYNTHESIS
   // sample count saturates
   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_SAMPLES))
      else $error("sample count past saturation");

   // extremes stay ordered once a point was seen
   a_extremes: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> max_ff >= min_ff)
      else $error("running max below running min");

   // an energy result always comes with a trapezoid point
   a_energy_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.energy_valid && !rsp_data_ff.status)
         |-> rsp_data_ff.filtered_valid)
      else $error("energy without a trapezoid point");
`endif

endmodule

@@ tb/trapezoidal_pulse_energy_checker.sv @@
// checker for the trapezoidal pulse energy block: watches the input, result
// and config ports, predicts every result word and compares it field by field
// depends on tpe_pkg
module trapezoidal_pulse_energy_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  tpe_pkg::req_word_type               req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  tpe_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_wr_en,
   input  tpe_pkg::csr_index_type              csr_index,
   input  logic [tpe_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   output int                                  mismatch_count,
   output int                                  points_in_flight
);
   import tpe_pkg::*;

   localparam int HIST_DEPTH = DEF_DELAY_DEPTH;
   localparam int SAMPLE_CAP = DEF_MAX_SAMPLES;

   // predictor state: register copies, sample history, running trapezoid
   logic [WIN_BITS-1:0]            win_setting;
   logic [GAP_BITS-1:0]            gap_setting;
   logic signed [SAMPLE_BITS-1:0]  hist [HIST_DEPTH];
   longint                         trap_sum;
   longint                         peak_hi;
   longint                         peak_lo;
   int unsigned                    seen_count;
   int unsigned                    wr_ptr;
   bit                             point_loaded;

   rsp_word_type                   trapezoid_points_q [$];
   rsp_word_type                   want;
   int                             miscompares;

   // sample taken back steps ago, zero before the waveform began
   function automatic longint tap(input int unsigned back);
      if (back > seen_count && seen_count < SAMPLE_CAP) return 0;
      return hist[(wr_ptr + HIST_DEPTH - back % HIST_DEPTH) % HIST_DEPTH];
   endfunction

   // one sample through the filter, returns the result word it causes
   function automatic rsp_word_type trapezoid_step(input req_word_type w);
      int unsigned win;
      int unsigned gap;
      int unsigned span;
      longint      x;
      bit          full_span;
      rsp_word_type r;
      // clamp the setup the way the block does
      win = win_setting;
      if (win == 0) win = 1;
      if (win > WIN_MAX) win = WIN_MAX;
      if (win > HIST_DEPTH / 2) win = HIST_DEPTH / 2;
      gap = gap_setting;
      if (gap > GAP_MAX) gap = GAP_MAX;
      if (2 * win + gap > HIST_DEPTH) gap = HIST_DEPTH - 2 * win;
      span = 2 * win + gap;

      // recursive update, then push the sample into the history
      x = $signed(w.sample);
      trap_sum += x - tap(win) - tap(win + gap) + tap(span);
      hist[wr_ptr] = w.sample;
      wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
      if (seen_count < SAMPLE_CAP) seen_count++;
      full_span = (seen_count >= span) || (seen_count >= SAMPLE_CAP);

      // running extremes, first point loads both
      if (full_span) begin
         if (!point_loaded) begin
            peak_hi = trap_sum;
            peak_lo = trap_sum;
            point_loaded = 1'b1;
         end else begin
            if (trap_sum > peak_hi) peak_hi = trap_sum;
            if (trap_sum < peak_lo) peak_lo = trap_sum;
         end
      end

      r = '0;
      if (full_span) begin
         r.filtered = trap_sum[FILT_BITS-1:0];
         r.filtered_valid = 1'b1;
      end

      // waveform close: energy or too short, then restart the waveform
      if (w.last) begin
         r.energy_valid = 1'b1;
         if (full_span && point_loaded)
            r.energy = ENERGY_BITS'((peak_hi - peak_lo) / longint'(win));
         else r.status = 1'b1;
         trap_sum = 0;
         seen_count = 0;
         peak_hi = 0;
         peak_lo = 0;
         point_loaded = 1'b0;
      end
      return r;
   endfunction

   function automatic int field_diff(input string name, input logic signed [63:0] exp_val,
                                     input logic signed [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   // sample all ports at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         win_setting = WIN_RESET;
         gap_setting = GAP_RESET;
         foreach (hist[i]) hist[i] = '0;
         trap_sum = 0;
         peak_hi = 0;
         peak_lo = 0;
         seen_count = 0;
         wr_ptr = 0;
         point_loaded = 1'b0;
         trapezoid_points_q.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: win_setting = csr_wr_data[WIN_BITS-1:0];
               CSR_GAP_LENGTH:    gap_setting = csr_wr_data[GAP_BITS-1:0];
               default: ;
            endcase
         end
         // accepted input word
         if (req_valid && req_ready)
            trapezoid_points_q.insert(trapezoid_points_q.size(), trapezoid_step(req_data));
         // accepted result word
         if (rsp_valid && rsp_ready) begin
            if (trapezoid_points_q.size() == 0) begin
               $error("result word arrived with no prediction pending");
               miscompares++;
            end else begin
               want = trapezoid_points_q.pop_front();
               miscompares += field_diff("filtered", want.filtered, rsp_data.filtered)
                  + field_diff("filtered_valid", want.filtered_valid, rsp_data.filtered_valid)
                  + field_diff("energy", want.energy, rsp_data.energy)
                  + field_diff("energy_valid", want.energy_valid, rsp_data.energy_valid)
                  + field_diff("status", want.status, rsp_data.status);
            end
         end
      end
      mismatch_count   <= miscompares;
      points_in_flight <= trapezoid_points_q.size();
   end

endmodule

@@ tb/trapezoidal_pulse_energy_top_test.sv @@
// testbench top for the trapezoidal pulse energy block: clock, reset,
// directed and random waveforms with idling and stalls, final verdict
// depends on tpe_pkg, trapezoidal_pulse_energy_top and the checker
module trapezoidal_pulse_energy_top_test;
   import tpe_pkg::*;

   localparam int     CLOCK_PERIOD = 10;
   localparam int     HOLD_CYCLES  = 200;
   localparam int     TAIL_CYCLES  = 60;
   localparam int     PHASE_WORDS  = 150;
   localparam int     LONG_WORDS   = 640;
   localparam int     LONG_GAP     = 100;
   localparam longint RUN_LIMIT    = 30_000_000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_word_type               req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_word_type               rsp_data;
   logic                       csr_wr_en;
   csr_index_type              csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wr_data;

   int mismatch_count;
   int points_in_flight;
   int tx_idle_pct;
   int rx_idle_pct;
   int tx_burst;
   int rx_burst;
   int hold_left;
   int hold_req;
   int hold_seen;
   int words_sent;
   int cur_win;
   int cur_gap;

   trapezoidal_pulse_energy_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   trapezoidal_pulse_energy_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, ready bursts and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         rx_burst = 0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rx_burst != 0) begin
         rx_burst = rx_burst - 1;
         rsp_ready <= 1'b1;
      end else begin
         if ($urandom_range(99) < 3) rx_burst = $urandom_range(60, 20);
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // offer one word, with random idle cycles ahead of it
   task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic fin);
      while (tx_burst == 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (tx_burst != 0) tx_burst--;
      else if ($urandom_range(99) < 2) tx_burst = $urandom_range(60, 20);
      req_valid <= 1'b1;
      req_data  <= '{sample: smp, last: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // stop offering and wait for every predicted result word
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
   endtask

   // write both registers, only while the block is idle
   task automatic write_setup(input int win_raw, input int gap_raw);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_WINDOW_LENGTH;
      csr_wr_data <= win_raw[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index   <= CSR_GAP_LENGTH;
      csr_wr_data <= gap_raw[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_win = win_raw;
      cur_gap = gap_raw;
   endtask

   // one random waveform, sometimes under a fresh setup
   task automatic random_waveform(input bit fresh);
      int r;
      int ew;
      int eg;
      int span;
      int len;
      int mode;
      int onset;
      int amp;
      int base;
      int v;
      // new setup: mostly short windows, now and then wide or raw values
      if (fresh || $urandom_range(3) == 0) begin
         drain();
         r = $urandom_range(99);
         if (r < 80) write_setup($urandom_range(6), $urandom_range(6));
         else if (r < 93) write_setup($urandom_range(40, 1), $urandom_range(60));
         else write_setup($urandom_range(1023), $urandom_range(1023));
      end
      if (fresh) hold_req <= hold_req + 1;

      // effective span of the current setup
      ew = cur_win % 512;
      if (ew == 0) ew = 1;
      if (ew > WIN_MAX) ew = WIN_MAX;
      eg = (cur_gap > GAP_MAX) ? GAP_MAX : cur_gap;
      span = 2 * ew + eg;

      // waveform length around the span, short when the span is large
      r = $urandom_range(99);
      if (r < 45) len = span + $urandom_range(30);
      else if (r < 60) len = span;
      else if (r < 70) len = (span > 1) ? span - 1 : 1;
      else len = $urandom_range(span + 2, 1);
      if (len > 200) len = $urandom_range(30, 1);

      // sample shapes: full random, step pulse, rail to rail, near zero
      mode  = $urandom_range(3);
      base  = int'($urandom_range(8191)) - 4096;
      amp   = int'($urandom_range(65535)) - 32768;
      onset = $urandom_range(len);
      for (int k = 0; k < len; k++) begin
         case (mode)
            0: v = int'($urandom_range(65535)) - 32768;
            1: v = base + ((k >= onset) ? amp : 0) + int'($urandom_range(64)) - 32;
            2: v = $urandom_range(1) ? 32767 : -32768;
            default: v = int'($urandom_range(8)) - 4;
         endcase
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         send_word(v[SAMPLE_BITS-1:0], k == len - 1);
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int word_goal);
      bit fresh;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      words_sent = 0;
      fresh = 1'b1;
      while (words_sent < word_goal) begin
         random_waveform(fresh);
         fresh = 1'b0;
      end
   endtask

   // stimulus
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_WINDOW_LENGTH;
      csr_wr_data = '0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero window acts as one, zero gap: span of two samples
      write_setup(0, 0);
      // single-sample waveform, too short
      send_word(-16'sd32768, 1'b1);
      // rail to rail swings
      send_word(16'sd32767, 1'b0);
      send_word(-16'sd32768, 1'b0);
      send_word(16'sd32767, 1'b0);
      send_word(-16'sd32768, 1'b1);
      send_word(16'sd0, 1'b0);
      send_word(-16'sd1, 1'b0);
      send_word(16'sd1, 1'b1);
      // setup change in the middle of an open waveform
      send_word(16'sh5555, 1'b0);
      send_word(-16'sd21846, 1'b0);
      send_word(16'sd100, 1'b0);
      drain();
      write_setup(3, 1);
      send_word(16'sd2000, 1'b0);
      send_word(-16'sd3000, 1'b0);
      send_word(16'sd4000, 1'b0);
      send_word(16'sd5, 1'b0);
      send_word(-16'sd7, 1'b1);
      // oversized window and gap clamp, stale history must read as zero
      drain();
      write_setup(1023, 1023);
      send_word(16'sd1234, 1'b0);
      send_word(-16'sd4321, 1'b0);
      send_word(16'sd7, 1'b1);
      send_word(16'sd32767, 1'b1);
      drain();

      // random waveforms under three idling mixes
      run_phase(16, 51, PHASE_WORDS);
      run_phase(51, 16, PHASE_WORDS);
      run_phase(0, 0, PHASE_WORDS);

      // widest window, one long waveform of full-scale pulses
      drain();
      write_setup(WIN_MAX, LONG_GAP);
      for (int k = 0; k < LONG_WORDS; k++) begin
         if (k < LONG_WORDS - 64)
            send_word(((k / 128) % 2) ? 16'sd32767 : -16'sd32768, 1'b0);
         else
            send_word(16'($urandom_range(65535)), k == LONG_WORDS - 1);
      end

      // drain and let any stray result word show up
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tpe_pkg.sv
rtl/tpe_ctrl.sv
rtl/tpe_datapath.sv
rtl/trapezoidal_pulse_energy_top.sv
tb/trapezoidal_pulse_energy_checker.sv
tb/trapezoidal_pulse_energy_top_test.sv
